// ----- src/assert_macros.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is high.
`define HWC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that must never hold, disabled while reset is high.
`define HWC_NEVER(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);

`endif

// ----- src/hwc_pkg.sv -----
// ----------------------------------------------------------------------------
// hwc_pkg
// Shared widths, state encodings and lane interface types for the HSV
// window train-and-classify block.
// ----------------------------------------------------------------------------
`default_nettype none

package hwc_pkg;

  localparam int COUNT_BITS = 16;
  localparam int LANES      = 3;
  localparam int CHAN_W     = 8;
  localparam int BOUND_W    = 9;
  localparam int GAIN_W     = 4;
  localparam int SUM_W      = COUNT_BITS + CHAN_W;
  localparam int SQ_W       = COUNT_BITS + 2 * CHAN_W;
  localparam int VAR_W      = 2 * CHAN_W;
  localparam int SPREAD_W   = VAR_W + GAIN_W;
  localparam int DIV_CNT_W  = $clog2(SQ_W + 1);

  localparam logic [BOUND_W-1:0]    BOUND_MAX  = BOUND_W'(256);
  localparam logic [GAIN_W-1:0]     GAIN_RESET = GAIN_W'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

  typedef enum logic [3:0] {
    LANE_IDLE,
    LANE_MEAN,
    LANE_PROD,
    LANE_SCALE,
    LANE_DEV,
    LANE_VSTART,
    LANE_VAR,
    LANE_BOUND,
    LANE_DONE
  } lane_state_t;

  typedef enum logic {
    TOP_IDLE,
    TOP_BUSY
  } top_state_t;

  typedef struct packed {
    logic accumulate;
    logic start;
    logic commit;
  } lane_ctrl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } lane_status_t;

endpackage

`default_nettype wire

// ----- src/hwc_div.sv -----
// ----------------------------------------------------------------------------
// hwc_div
// Restoring divider, one quotient bit per cycle. Pulses done with the
// quotient held until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module hwc_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [hwc_pkg::SQ_W-1:0]       dividend,
  input  wire logic [hwc_pkg::COUNT_BITS-1:0] divisor,
  output logic                                done,
  output logic [hwc_pkg::SQ_W-1:0]            quotient
);

  logic                             active;
  logic [hwc_pkg::DIV_CNT_W-1:0]    cnt;
  logic [hwc_pkg::COUNT_BITS-1:0]   rem;
  logic [hwc_pkg::SQ_W-1:0]         quo;
  logic [hwc_pkg::COUNT_BITS:0]     shifted;
  logic [hwc_pkg::COUNT_BITS:0]     diff;
  logic                             fits;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, quo[hwc_pkg::SQ_W-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  // Control: iteration count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= hwc_pkg::DIV_CNT_W'(hwc_pkg::SQ_W);
      end else if (active) begin
        cnt <= cnt - hwc_pkg::DIV_CNT_W'(1);
        if (cnt == hwc_pkg::DIV_CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (active) begin
      quo <= {quo[hwc_pkg::SQ_W-2:0], fits};
      rem <= fits ? diff[hwc_pkg::COUNT_BITS-1:0] : shifted[hwc_pkg::COUNT_BITS-1:0];
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ----- src/hwc_lane.sv -----
// ----------------------------------------------------------------------------
// hwc_lane
// One color channel: training accumulators, window bounds, pixel compare
// and the sequencer that turns the sums into a new window.
// ----------------------------------------------------------------------------
`default_nettype none

module hwc_lane (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire hwc_pkg::lane_ctrl_t            ctrl,
  input  wire logic [hwc_pkg::CHAN_W-1:0]     px,
  input  wire logic [hwc_pkg::COUNT_BITS-1:0] n,
  input  wire logic [hwc_pkg::GAIN_W-1:0]     gain,
  output hwc_pkg::lane_status_t               status,
  output logic [hwc_pkg::BOUND_W-1:0]         win_low,
  output logic [hwc_pkg::BOUND_W-1:0]         win_high,
  output logic [hwc_pkg::BOUND_W-1:0]         cand_low,
  output logic [hwc_pkg::BOUND_W-1:0]         cand_high
);

  hwc_pkg::lane_state_t state, state_next;

  logic [hwc_pkg::SUM_W-1:0]     sum;
  logic [hwc_pkg::SQ_W-1:0]      sq;
  logic [2*hwc_pkg::CHAN_W-1:0]  px_sq;

  logic [hwc_pkg::CHAN_W-1:0]    mean;
  logic [2*hwc_pkg::CHAN_W-1:0]  p_mm;
  logic [hwc_pkg::SQ_W-1:0]      p_ms;
  logic [hwc_pkg::SQ_W-1:0]      p_nmm;
  logic [hwc_pkg::SQ_W-1:0]      dev;
  logic [hwc_pkg::SQ_W+1:0]      dev_full;
  logic [hwc_pkg::VAR_W-1:0]     var_q;
  logic [hwc_pkg::SPREAD_W-1:0]  spread;
  logic [hwc_pkg::SPREAD_W-1:0]  mean_wide;
  logic [hwc_pkg::SPREAD_W-1:0]  low_diff;
  logic [hwc_pkg::SPREAD_W:0]    high_sum;

  logic                          div_start;
  logic [hwc_pkg::SQ_W-1:0]      div_dividend;
  logic                          div_done;
  logic [hwc_pkg::SQ_W-1:0]      div_quo;

  hwc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sample square for the accumulator
  assign px_sq = (2*hwc_pkg::CHAN_W)'(px) * (2*hwc_pkg::CHAN_W)'(px);

  // Deviation and bound arithmetic
  always_comb begin
    dev_full  = {2'b00, sq} + {2'b00, p_nmm} - {1'b0, p_ms, 1'b0};
    spread    = hwc_pkg::SPREAD_W'(gain) * hwc_pkg::SPREAD_W'(var_q);
    mean_wide = hwc_pkg::SPREAD_W'(mean);
    low_diff  = mean_wide - spread;
    high_sum  = {1'b0, spread} + {1'b0, mean_wide};
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      hwc_pkg::LANE_IDLE:   if (ctrl.start) state_next = hwc_pkg::LANE_MEAN;
      hwc_pkg::LANE_MEAN:   if (div_done) state_next = hwc_pkg::LANE_PROD;
      hwc_pkg::LANE_PROD:   state_next = hwc_pkg::LANE_SCALE;
      hwc_pkg::LANE_SCALE:  state_next = hwc_pkg::LANE_DEV;
      hwc_pkg::LANE_DEV:    state_next = hwc_pkg::LANE_VSTART;
      hwc_pkg::LANE_VSTART: state_next = hwc_pkg::LANE_VAR;
      hwc_pkg::LANE_VAR:    if (div_done) state_next = hwc_pkg::LANE_BOUND;
      hwc_pkg::LANE_BOUND:  state_next = hwc_pkg::LANE_DONE;
      hwc_pkg::LANE_DONE:   if (ctrl.commit) state_next = hwc_pkg::LANE_IDLE;
      default:              state_next = hwc_pkg::LANE_IDLE;
    endcase
  end

  // Outputs: divider launch and status
  always_comb begin
    div_start    = 1'b0;
    div_dividend = hwc_pkg::SQ_W'(sum);
    case (state)
      hwc_pkg::LANE_IDLE: begin
        div_start    = ctrl.start;
        // fold in the closing sample, which reaches sum at this same edge
        div_dividend = ctrl.accumulate ? hwc_pkg::SQ_W'(sum) + hwc_pkg::SQ_W'(px)
                                       : hwc_pkg::SQ_W'(sum);
      end
      hwc_pkg::LANE_VSTART: begin
        div_start    = 1'b1;
        div_dividend = dev;
      end
      default: begin
        div_start    = 1'b0;
        div_dividend = hwc_pkg::SQ_W'(sum);
      end
    endcase
    status.done = (state == hwc_pkg::LANE_DONE);
    status.hit  = ({1'b0, px} >= win_low) && ({1'b0, px} <= win_high);
  end

  // State, accumulators and window; commit loads the window and clears sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hwc_pkg::LANE_IDLE;
      sum      <= '0;
      sq       <= '0;
      win_low  <= '0;
      win_high <= hwc_pkg::BOUND_MAX;
    end else begin
      state <= state_next;
      if (ctrl.commit) begin
        sum      <= '0;
        sq       <= '0;
        win_low  <= cand_low;
        win_high <= cand_high;
      end else if (ctrl.accumulate) begin
        sum <= sum + hwc_pkg::SUM_W'(px);
        sq  <= sq + hwc_pkg::SQ_W'(px_sq);
      end
    end
  end

  // Working registers of the window computation
  always_ff @(posedge clk) begin
    case (state)
      hwc_pkg::LANE_MEAN: begin
        if (div_done) mean <= div_quo[hwc_pkg::CHAN_W-1:0];
      end
      hwc_pkg::LANE_PROD: begin
        p_mm <= (2*hwc_pkg::CHAN_W)'(mean) * (2*hwc_pkg::CHAN_W)'(mean);
        p_ms <= hwc_pkg::SQ_W'(mean) * hwc_pkg::SQ_W'(sum);
      end
      hwc_pkg::LANE_SCALE: begin
        p_nmm <= hwc_pkg::SQ_W'(p_mm) * hwc_pkg::SQ_W'(n);
      end
      hwc_pkg::LANE_DEV: begin
        dev <= dev_full[hwc_pkg::SQ_W-1:0];
      end
      hwc_pkg::LANE_VAR: begin
        if (div_done) var_q <= div_quo[hwc_pkg::VAR_W-1:0];
      end
      hwc_pkg::LANE_BOUND: begin
        cand_low  <= (spread >= mean_wide) ? '0 : low_diff[hwc_pkg::BOUND_W-1:0];
        cand_high <= (high_sum > (hwc_pkg::SPREAD_W + 1)'(hwc_pkg::BOUND_MAX))
                     ? hwc_pkg::BOUND_MAX : high_sum[hwc_pkg::BOUND_W-1:0];
      end
      default: begin
        mean <= mean;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/hsv_window_train_and_classify.sv -----
// ----------------------------------------------------------------------------
// hsv_window_train_and_classify
// Trainable per-channel HSV window with an in-range pixel classifier.
// ----------------------------------------------------------------------------
// Classify items and ordinary training items transfer one per cycle while the
// block is idle and the output is free, and each yields its result in the
// output register the next cycle. A training item flagged last_sample stalls
// the input until commit: each of the three channel lanes runs its bit-serial
// divider twice, once for the mean and once for the deviation, with multiply
// and bound steps in between; the lanes run in lock step and the merge stage
// commits the new windows and emits the result with window_updated set.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hsv_window_train_and_classify (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [hwc_pkg::GAIN_W-1:0]  cfg_wdata,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        mode,
  input  wire logic [hwc_pkg::CHAN_W-1:0]  hue,
  input  wire logic [hwc_pkg::CHAN_W-1:0]  saturation,
  input  wire logic [hwc_pkg::CHAN_W-1:0]  brightness,
  input  wire logic                        last_sample,
  // output channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             in_range,
  output logic                             window_updated,
  output logic [hwc_pkg::BOUND_W-1:0]      lower_hue,
  output logic [hwc_pkg::BOUND_W-1:0]      lower_sat,
  output logic [hwc_pkg::BOUND_W-1:0]      lower_val,
  output logic [hwc_pkg::BOUND_W-1:0]      upper_hue,
  output logic [hwc_pkg::BOUND_W-1:0]      upper_sat,
  output logic [hwc_pkg::BOUND_W-1:0]      upper_val
);

  hwc_pkg::top_state_t state, state_next;

  logic [hwc_pkg::GAIN_W-1:0]     gain;
  logic [hwc_pkg::COUNT_BITS-1:0] count;
  logic [hwc_pkg::COUNT_BITS-1:0] n;

  logic in_accept;
  logic train_accept;
  logic last_accept;
  logic out_free;
  logic commit;
  logic all_done;
  logic all_hit;

  logic [hwc_pkg::CHAN_W-1:0]  px       [hwc_pkg::LANES];
  hwc_pkg::lane_ctrl_t         lane_ctrl;
  hwc_pkg::lane_status_t       lane_status [hwc_pkg::LANES];
  logic [hwc_pkg::LANES-1:0]   done_vec;
  logic [hwc_pkg::LANES-1:0]   hit_vec;
  logic [hwc_pkg::BOUND_W-1:0] win_low  [hwc_pkg::LANES];
  logic [hwc_pkg::BOUND_W-1:0] win_high [hwc_pkg::LANES];
  logic [hwc_pkg::BOUND_W-1:0] cand_low [hwc_pkg::LANES];
  logic [hwc_pkg::BOUND_W-1:0] cand_high[hwc_pkg::LANES];
  logic [hwc_pkg::BOUND_W-1:0] out_low  [hwc_pkg::LANES];
  logic [hwc_pkg::BOUND_W-1:0] out_high [hwc_pkg::LANES];

  // Handshake decode
  always_comb begin
    out_free     = !out_valid || !out_stall;
    in_stall     = (state != hwc_pkg::TOP_IDLE) || !out_free;
    in_accept    = in_valid && !in_stall;
    train_accept = in_accept && !mode;
    last_accept  = train_accept && last_sample;
    n            = (count == '0) ? hwc_pkg::COUNT_BITS'(1) : count;
  end

  // Channel lanes
  assign px[0] = hue;
  assign px[1] = saturation;
  assign px[2] = brightness;

  always_comb begin
    lane_ctrl.accumulate = train_accept && (count != hwc_pkg::COUNT_MAX);
    lane_ctrl.start      = last_accept;
    lane_ctrl.commit     = commit;
  end

  for (genvar i = 0; i < hwc_pkg::LANES; i++) begin : g_lane
    hwc_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (lane_ctrl),
      .px        (px[i]),
      .n         (n),
      .gain      (gain),
      .status    (lane_status[i]),
      .win_low   (win_low[i]),
      .win_high  (win_high[i]),
      .cand_low  (cand_low[i]),
      .cand_high (cand_high[i])
    );
    assign done_vec[i] = lane_status[i].done;
    assign hit_vec[i]  = lane_status[i].hit;
  end

  // Merge lane results
  always_comb begin
    all_done = &done_vec;
    all_hit  = &hit_vec;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      hwc_pkg::TOP_IDLE: if (last_accept) state_next = hwc_pkg::TOP_BUSY;
      hwc_pkg::TOP_BUSY: if (all_done && out_free) state_next = hwc_pkg::TOP_IDLE;
      default:           state_next = hwc_pkg::TOP_IDLE;
    endcase
  end

  // Commit once every lane holds its window and the output slot is open
  always_comb begin
    case (state)
      hwc_pkg::TOP_BUSY: commit = all_done && out_free;
      default:           commit = 1'b0;
    endcase
  end

  // Gain register, sample count and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hwc_pkg::TOP_IDLE;
      gain  <= hwc_pkg::GAIN_RESET;
      count <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) gain <= cfg_wdata;
      if (commit) begin
        count <= '0;
      end else if (lane_ctrl.accumulate) begin
        count <= count + hwc_pkg::COUNT_BITS'(1);
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit || (in_accept && !last_accept)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (commit) begin
      in_range       <= 1'b0;
      window_updated <= 1'b1;
      out_low        <= cand_low;
      out_high       <= cand_high;
    end else if (in_accept && !last_accept) begin
      in_range       <= mode && all_hit;
      window_updated <= 1'b0;
      out_low        <= win_low;
      out_high       <= win_high;
    end
  end

  assign lower_hue = out_low[0];
  assign lower_sat = out_low[1];
  assign lower_val = out_low[2];
  assign upper_hue = out_high[0];
  assign upper_sat = out_high[1];
  assign upper_val = out_high[2];

  // Checks
  `HWC_ASSERT(a_lanes_lock_step, clk, rst, (done_vec == '0) || (done_vec == '1), "lanes out of step")
  `HWC_ASSERT(a_commit_clears_count, clk, rst, commit |=> (count == '0), "count not cleared")
  `HWC_ASSERT(a_commit_emits, clk, rst, commit |=> (out_valid && window_updated), "no update result")
  `HWC_NEVER(a_done_while_idle, clk, rst, (state == hwc_pkg::TOP_IDLE) && all_done, "stray done")

endmodule

`default_nettype wire
